// File: sv/hhq_pkg.sv
// Shared widths, codes and constants of the heightmap height query block.
`default_nettype none

package hhq_pkg;

  localparam int unsigned HEIGHT_W   = 24;
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned SPACING_W  = 16;
  localparam int unsigned GRID_W     = 9;
  localparam int unsigned CELL_W     = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned DEF_MAX_COLUMNS = 256;
  localparam int unsigned DEF_MAX_ROWS    = 256;

  // final division: |num| < den * 2^26, so 27 quotient bits over a 32 bit divisor
  localparam int unsigned DEN_W  = 2 * SPACING_W;
  localparam int unsigned FQ_W   = 27;
  localparam int unsigned NUM_W  = FQ_W + DEN_W + 1;
  localparam int unsigned TERM_W = HEIGHT_W + 1 + SPACING_W + 1;

  localparam logic [SPACING_W-1:0] SPACING_RST = SPACING_W'(256);
  localparam logic [GRID_W-1:0]    GRID_RST    = GRID_W'(256);

  localparam logic [FQ_W-1:0] QUOT_POS_MAX = FQ_W'((2 ** (HEIGHT_W - 1)) - 1);
  localparam logic [FQ_W-1:0] QUOT_NEG_MAX = FQ_W'(2 ** (HEIGHT_W - 1));
  localparam logic [HEIGHT_W-1:0] HEIGHT_POS_SAT = {1'b0, {(HEIGHT_W - 1){1'b1}}};
  localparam logic [HEIGHT_W-1:0] HEIGHT_NEG_SAT = {1'b1, {(HEIGHT_W - 1){1'b0}}};

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPACING_X    = 8'd0,
    CFG_SPACING_Z    = 8'd1,
    CFG_GRID_COLUMNS = 8'd2,
    CFG_GRID_ROWS    = 8'd3
  } cfg_reg_e;

endpackage

`default_nettype wire

// File: sv/hhq_if.sv
// Handshake interfaces of the heightmap height query block.
`default_nettype none

interface hhq_in_if;
  import hhq_pkg::*;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [CELL_W-1:0]   cell_col;
  logic [CELL_W-1:0]   cell_row;
  logic [HEIGHT_W-1:0] height_value;
  logic [COORD_W-1:0]  query_x;
  logic [COORD_W-1:0]  query_z;
  modport source (output valid, cmd, cell_col, cell_row, height_value, query_x, query_z,
                  input ready);
  modport sink (input valid, cmd, cell_col, cell_row, height_value, query_x, query_z,
                output ready);
endinterface

interface hhq_out_if;
  import hhq_pkg::*;
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height_out;
  logic                out_of_range;
  modport source (output valid, height_out, out_of_range, input ready);
  modport sink (input valid, height_out, out_of_range, output ready);
endinterface

interface hhq_cfg_if;
  import hhq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// File: sv/hhq_udiv.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`default_nettype none

module hhq_udiv #(
  parameter int unsigned Q_W   = 24,
  parameter int unsigned D_W   = 16,
  parameter int unsigned TAG_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  logic [Q_W+D_W-1:0] num_i,
  input  logic [D_W-1:0]     den_i,
  input  logic [TAG_W-1:0]   tag_i,
  output logic               valid_o,
  output logic [Q_W-1:0]     quot_o,
  output logic [D_W-1:0]     rem_o,
  output logic [TAG_W-1:0]   tag_o
);

  // numerator must satisfy num < den << Q_W
  logic               vld_q [Q_W];
  logic [D_W-1:0]     rem_q [Q_W];
  logic [Q_W-1:0]     low_q [Q_W];
  logic [D_W-1:0]     den_q [Q_W];
  logic [TAG_W-1:0]   tag_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic             vld_in;
    logic [D_W-1:0]   rem_in;
    logic [Q_W-1:0]   low_in;
    logic [D_W-1:0]   den_in;
    logic [TAG_W-1:0] tag_in;
    logic [D_W:0]     trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = num_i[Q_W+D_W-1:Q_W];
      assign low_in = num_i[Q_W-1:0];
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign trial = {rem_in, low_in[Q_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k] <= ge ? D_W'(trial - {1'b0, den_in}) : D_W'(trial);
        low_q[k] <= {low_in[Q_W-2:0], ge};
        den_q[k] <= den_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quot_o  = low_q[Q_W-1];
  assign rem_o   = rem_q[Q_W-1];
  assign tag_o   = tag_q[Q_W-1];

endmodule

`default_nettype wire

// File: sv/heightmap_height_query.sv
// An accepted query passes 24 cell division stages, five stages of height fetch and plane
// arithmetic, 27 final division stages and the output register before its result appears.
// Throughput: one item per cycle; the whole pipeline holds while the output waits.
// Writes pass through the cell division stages and update the height store in order.
// Reset clears valid bits and restores configuration defaults; height store undefined.
`default_nettype none

module heightmap_height_query #(
  parameter int unsigned MAX_COLUMNS = hhq_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = hhq_pkg::DEF_MAX_ROWS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hhq_in_if.sink     in_i,
  hhq_out_if.source  out_o,
  hhq_cfg_if.sink    cfg_i
);
  import hhq_pkg::*;

  localparam int unsigned XW      = $clog2(MAX_COLUMNS);
  localparam int unsigned ZW      = $clog2(MAX_ROWS);
  localparam int unsigned XHW     = (XW > 1) ? XW - 1 : 1;
  localparam int unsigned ZHW     = (ZW > 1) ? ZW - 1 : 1;
  localparam int unsigned BANK_AW = XHW + ZHW;
  localparam int unsigned TAGX_W  = XW + ZW + HEIGHT_W;

  logic [SPACING_W-1:0] spacing_x_q, spacing_z_q;
  logic [GRID_W-1:0]    grid_columns_q, grid_rows_q;

  logic adv;
  logic out_valid_q;
  logic [HEIGHT_W-1:0] out_height_q;
  logic out_oor_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_x_q    <= SPACING_RST;
      spacing_z_q    <= SPACING_RST;
      grid_columns_q <= GRID_RST;
      grid_rows_q    <= GRID_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        CFG_SPACING_X:    spacing_x_q    <= cfg_i.wdata;
        CFG_SPACING_Z:    spacing_z_q    <= cfg_i.wdata;
        CFG_GRID_COLUMNS: grid_columns_q <= GRID_W'(cfg_i.wdata);
        CFG_GRID_ROWS:    grid_rows_q    <= GRID_W'(cfg_i.wdata);
        default: ;
      endcase
    end
  end

  // cell division
  logic                 in_acc, in_wr_ok;
  logic                 dx_vld, dz_vld;
  logic [COORD_W-1:0]   cx, cz;
  logic [SPACING_W-1:0] rem_x, rem_z;
  logic [TAGX_W-1:0]    tag_x;
  logic [1:0]           tag_z;

  assign in_acc   = in_i.valid && adv;
  assign in_wr_ok = (32'(in_i.cell_col) < MAX_COLUMNS) && (32'(in_i.cell_row) < MAX_ROWS);

  hhq_udiv #(.Q_W(COORD_W), .D_W(SPACING_W), .TAG_W(TAGX_W)) u_div_x (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(in_acc),
    .num_i({{SPACING_W{1'b0}}, in_i.query_x}), .den_i(spacing_x_q),
    .tag_i({XW'(in_i.cell_col), ZW'(in_i.cell_row), in_i.height_value}),
    .valid_o(dx_vld), .quot_o(cx), .rem_o(rem_x), .tag_o(tag_x)
  );

  hhq_udiv #(.Q_W(COORD_W), .D_W(SPACING_W), .TAG_W(2)) u_div_z (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(in_acc),
    .num_i({{SPACING_W{1'b0}}, in_i.query_z}), .den_i(spacing_z_q),
    .tag_i({in_i.cmd, in_wr_ok}),
    .valid_o(dz_vld), .quot_o(cz), .rem_o(rem_z), .tag_o(tag_z)
  );

  // range check and banked height fetch
  logic [GRID_W-1:0]   cols_eff, rows_eff;
  logic                a_oor_d, a_vld_d, wr_go;
  logic [XW-1:0]       cxs, wcol;
  logic [ZW-1:0]       czs, wrow;
  logic [HEIGHT_W-1:0] wdata;
  logic [1:0]          wbank;
  logic [BANK_AW-1:0]  waddr;

  assign cols_eff = (32'(grid_columns_q) > MAX_COLUMNS) ? GRID_W'(MAX_COLUMNS) : grid_columns_q;
  assign rows_eff = (32'(grid_rows_q) > MAX_ROWS) ? GRID_W'(MAX_ROWS) : grid_rows_q;
  assign a_oor_d  = (spacing_x_q == '0) || (spacing_z_q == '0)
                 || ((25'(cx) + 25'd1) >= 25'(cols_eff))
                 || ((25'(cz) + 25'd1) >= 25'(rows_eff));
  assign a_vld_d  = dx_vld && dz_vld && (tag_z[1] == CMD_QUERY);
  assign cxs      = XW'(cx);
  assign czs      = ZW'(cz);

  assign {wcol, wrow, wdata} = tag_x;
  assign wr_go = adv && dx_vld && (tag_z[1] == CMD_WRITE) && tag_z[0];
  assign wbank = {wrow[0], wcol[0]};
  assign waddr = {ZHW'(wrow >> 1), XHW'(wcol >> 1)};

  logic [3:0][HEIGHT_W-1:0] rd_q;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic COLP = (b % 2) == 1;
    localparam logic ROWP = (b / 2) == 1;
    logic [HEIGHT_W-1:0] mem_q [2 ** BANK_AW];
    logic [BANK_AW-1:0]  raddr;

    assign raddr = {ZHW'(czs >> 1) + ZHW'(czs[0] & ~ROWP),
                    XHW'(cxs >> 1) + XHW'(cxs[0] & ~COLP)};

    always_ff @(posedge clk_i) begin
      if (wr_go && (wbank == 2'(b))) begin
        mem_q[waddr] <= wdata;
      end
      if (adv) begin
        rd_q[b] <= mem_q[raddr];
      end
    end
  end

  logic a_vld_q, a_oor_q, a_cxp_q, a_czp_q;
  logic [SPACING_W-1:0] a_dx_q, a_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= a_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_oor_q <= a_oor_d;
      a_cxp_q <= cx[0];
      a_czp_q <= cz[0];
      a_dx_q  <= rem_x;
      a_dz_q  <= rem_z;
    end
  end

  // triangle pick, edge differences, first products
  logic signed [HEIGHT_W-1:0] h00, h10, h01, h11;
  logic signed [HEIGHT_W:0]   d1, d2;

  assign h00 = rd_q[{a_czp_q, a_cxp_q}];
  assign h10 = rd_q[{a_czp_q, ~a_cxp_q}];
  assign h01 = rd_q[{~a_czp_q, a_cxp_q}];
  assign h11 = rd_q[{~a_czp_q, ~a_cxp_q}];

  always_comb begin
    if (a_dx_q > a_dz_q) begin
      d1 = {h10[HEIGHT_W-1], h10} - {h00[HEIGHT_W-1], h00};
      d2 = {h11[HEIGHT_W-1], h11} - {h10[HEIGHT_W-1], h10};
    end else begin
      d1 = {h11[HEIGHT_W-1], h11} - {h01[HEIGHT_W-1], h01};
      d2 = {h01[HEIGHT_W-1], h01} - {h00[HEIGHT_W-1], h00};
    end
  end

  logic b_vld_q, b_oor_q;
  logic signed [HEIGHT_W-1:0] b_h00_q;
  logic signed [TERM_W-1:0]   b_t1_q, b_t2_q;
  logic [DEN_W-1:0]           b_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_oor_q <= a_oor_q;
      b_h00_q <= h00;
      b_t1_q  <= d1 * signed'({1'b0, a_dx_q});
      b_t2_q  <= d2 * signed'({1'b0, a_dz_q});
      b_den_q <= DEN_W'(spacing_x_q) * DEN_W'(spacing_z_q);
    end
  end

  // scaled terms
  logic c_vld_q, c_oor_q;
  logic signed [HEIGHT_W+DEN_W:0]  c_p0_q;
  logic signed [TERM_W+SPACING_W:0] c_p1_q, c_p2_q;
  logic [DEN_W-1:0] c_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (adv) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_oor_q <= b_oor_q;
      c_p0_q  <= b_h00_q * signed'({1'b0, b_den_q});
      c_p1_q  <= b_t1_q * signed'({1'b0, spacing_z_q});
      c_p2_q  <= b_t2_q * signed'({1'b0, spacing_x_q});
      c_den_q <= b_den_q;
    end
  end

  // numerator sum, then magnitude and sign
  logic d_vld_q, d_oor_q;
  logic signed [NUM_W-1:0] d_num_q;
  logic [DEN_W-1:0] d_den_q;
  logic e_vld_q, e_oor_q, e_neg_q;
  logic [NUM_W-2:0] e_mag_q;
  logic [DEN_W-1:0] e_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else if (adv) begin
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_oor_q <= c_oor_q;
      d_num_q <= NUM_W'(c_p0_q) + NUM_W'(c_p1_q) + NUM_W'(c_p2_q);
      d_den_q <= c_den_q;
      e_oor_q <= d_oor_q;
      e_neg_q <= d_num_q[NUM_W-1];
      e_mag_q <= (NUM_W-1)'(d_num_q[NUM_W-1] ? -d_num_q : d_num_q);
      e_den_q <= d_den_q;
    end
  end

  // truncating division by sx*sz
  logic            f_vld;
  logic [FQ_W-1:0] f_quot;
  logic [1:0]      f_tag;

  hhq_udiv #(.Q_W(FQ_W), .D_W(DEN_W), .TAG_W(2)) u_div_h (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(e_vld_q),
    .num_i(e_mag_q), .den_i(e_den_q), .tag_i({e_neg_q, e_oor_q}),
    .valid_o(f_vld), .quot_o(f_quot), .rem_o(), .tag_o(f_tag)
  );

  logic [HEIGHT_W-1:0] sat_height;

  always_comb begin
    if (f_tag[0]) begin
      sat_height = '0;
    end else if (f_tag[1]) begin
      sat_height = (f_quot > QUOT_NEG_MAX) ? HEIGHT_NEG_SAT : HEIGHT_W'(-f_quot);
    end else begin
      sat_height = (f_quot > QUOT_POS_MAX) ? HEIGHT_POS_SAT : HEIGHT_W'(f_quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= f_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_height_q <= sat_height;
      out_oor_q    <= f_tag[0];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.height_out   = out_height_q;
  assign out_o.out_of_range = out_oor_q;

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_oor_q |-> out_height_q == '0)
    else $error("out of range result carries a height");

  a_zero_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q && (spacing_x_q == '0 || spacing_z_q == '0) |-> a_oor_q)
    else $error("zero spacing query not flagged");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q && !b_oor_q |-> b_den_q != '0)
    else $error("in range query with zero divisor");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(e_vld_q) && $stable(b_vld_q))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the heightmap height query block: directed and random items.
`timescale 1ns / 1ps

module tb_top;
  import hhq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'hFF;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE  = 8'h04;
  localparam int STORE_COLS  = DEF_MAX_COLUMNS;
  localparam int STORE_ROWS  = DEF_MAX_ROWS;
  localparam int DRAIN_WAIT  = 70;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [HEIGHT_W-1:0] height;
    logic                oor;
  } height_result_t;

  class height_scoreboard;
    logic [HEIGHT_W-1:0]  heights [STORE_COLS*STORE_ROWS];
    bit                   written [STORE_COLS*STORE_ROWS];
    height_result_t       pending [$];
    logic [SPACING_W-1:0] sx, sz;
    logic [GRID_W-1:0]    gcols, grows;
    int errors, shown, n_query, n_write, n_oor;

    function void reset_regs();
      sx = SPACING_RST; sz = SPACING_RST; gcols = GRID_RST; grows = GRID_RST;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_SPACING_X:    sx = d;
        CFG_SPACING_Z:    sz = d;
        CFG_GRID_COLUMNS: gcols = d[GRID_W-1:0];
        CFG_GRID_ROWS:    grows = d[GRID_W-1:0];
        default: ;
      endcase
    endfunction

    // cell lookup; returns 1 when the query lands in a usable cell
    function bit locate(logic [COORD_W-1:0] qx, logic [COORD_W-1:0] qz,
                        output int cx, output int cz);
      int cols, rows;
      cols = (gcols > STORE_COLS) ? STORE_COLS : gcols;
      rows = (grows > STORE_ROWS) ? STORE_ROWS : grows;
      cx = 0; cz = 0;
      if (cols < 2 || rows < 2 || sx == 0 || sz == 0) return 0;
      cx = qx / sx;
      cz = qz / sz;
      return (cx < cols - 1) && (cz < rows - 1);
    endfunction

    function longint vtx(int c, int r);
      return longint'($signed(heights[r*STORE_COLS + c]));
    endfunction

    function void note_item(cmd_e cmd, logic [CELL_W-1:0] col, logic [CELL_W-1:0] row,
                            logic [HEIGHT_W-1:0] hv, logic [COORD_W-1:0] qx,
                            logic [COORD_W-1:0] qz);
      height_result_t r;
      int cx, cz;
      longint dx, dz, h00, h10, h01, h11, d1, d2, num, den, res;
      if (cmd == CMD_WRITE) begin
        heights[{row, col}] = hv;
        written[{row, col}] = 1;
        n_write++;
        return;
      end
      n_query++;
      r.height = '0;
      r.oor = 1'b1;
      if (locate(qx, qz, cx, cz)) begin
        dx = longint'(qx) - longint'(cx) * sx;
        dz = longint'(qz) - longint'(cz) * sz;
        h00 = vtx(cx, cz);     h10 = vtx(cx + 1, cz);
        h01 = vtx(cx, cz + 1); h11 = vtx(cx + 1, cz + 1);
        if (dx > dz) begin
          d1 = h10 - h00; d2 = h11 - h10;
        end else begin
          d1 = h11 - h01; d2 = h01 - h00;
        end
        den = longint'(sx) * longint'(sz);
        num = h00 * den + d1 * dx * sz + d2 * dz * sx;
        res = num / den;
        if (res > 64'sd8388607) res = 64'sd8388607;
        if (res < -64'sd8388608) res = -64'sd8388608;
        r.height = res[HEIGHT_W-1:0];
        r.oor = 1'b0;
      end else begin
        n_oor++;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [HEIGHT_W-1:0] h, logic oor);
      height_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (shown++ < 10) $display("unexpected result height=%h oor=%b", h, oor);
        return;
      end
      e = pending.pop_front();
      if (h !== e.height || oor !== e.oor) begin
        errors++;
        if (shown++ < 10)
          $display("mismatch: exp height=%h oor=%b, got height=%h oor=%b",
                   e.height, e.oor, h, oor);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  hhq_in_if  in_if ();
  hhq_out_if out_if ();
  hhq_cfg_if cfg_if ();

  heightmap_height_query DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  height_scoreboard sb = new();
  bit calm;
  int hold_left;
  int sink_gap;
  int n_cfg;

  // result side: random back-pressure, long hold on request
  always @(negedge clk_i) begin
    if (!calm && hold_left == 0 && sink_gap == 0 && $urandom_range(0, 5) == 0)
      sink_gap = $urandom_range(1, 19);
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.height_out, out_if.out_of_range);

  task automatic put_item(cmd_e cmd, logic [CELL_W-1:0] col, logic [CELL_W-1:0] row,
                          logic [HEIGHT_W-1:0] hv, logic [COORD_W-1:0] qx,
                          logic [COORD_W-1:0] qz);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.cmd <= cmd;
    in_if.cell_col <= col;
    in_if.cell_row <= row;
    in_if.height_value <= hv;
    in_if.query_x <= qx;
    in_if.query_z <= qz;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(cmd, col, row, hv, qx, qz);
  endtask

  function automatic logic [HEIGHT_W-1:0] rand_height();
    case ($urandom_range(0, 7))
      0: return HEIGHT_POS_SAT;
      1: return HEIGHT_NEG_SAT;
      default: return HEIGHT_W'($urandom);
    endcase
  endfunction

  task automatic put_write(int col, int row, logic [HEIGHT_W-1:0] h);
    put_item(CMD_WRITE, col[CELL_W-1:0], row[CELL_W-1:0], h,
             COORD_W'($urandom), COORD_W'($urandom));
  endtask

  // fills any unwritten corner of the target cell, then queries
  task automatic put_query(logic [COORD_W-1:0] qx, logic [COORD_W-1:0] qz);
    int cx, cz;
    if (sb.locate(qx, qz, cx, cz)) begin
      for (int k = 0; k < 4; k++)
        if (!sb.written[(cz + k / 2) * STORE_COLS + cx + k % 2])
          put_write(cx + k % 2, cz + k / 2, rand_height());
    end
    put_item(CMD_QUERY, CELL_W'($urandom), CELL_W'($urandom), HEIGHT_W'($urandom), qx, qz);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(int s, int n);
    longint lim;
    if (n > STORE_COLS) n = STORE_COLS;
    if (s == 0 || n < 2 || $urandom_range(0, 9) == 0) return COORD_W'($urandom);
    lim = longint'(n - 1) * s - 1;
    if ($urandom_range(0, 7) == 0) lim += s + 1;
    if (lim > 64'hFFFFFF) lim = 64'hFFFFFF;
    if (lim < 0) lim = 0;
    return COORD_W'($urandom_range(0, int'(lim)));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_reg(idx, d);
    n_cfg++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_grid(int sx, int sz, int c, int r);
    write_reg(CFG_SPACING_X, CFG_DATA_W'(sx));
    write_reg(CFG_SPACING_Z, CFG_DATA_W'(sz));
    write_reg(CFG_GRID_COLUMNS, CFG_DATA_W'(c));
    write_reg(CFG_GRID_ROWS, CFG_DATA_W'(r));
  endtask

  task automatic random_run(int count);
    logic [COORD_W-1:0] qx, qz;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        put_write($urandom_range(0, 255), $urandom_range(0, 255), rand_height());
      end else begin
        qx = pick_coord(sb.sx, sb.gcols);
        qz = pick_coord(sb.sz, sb.grows);
        // diagonal of the cell
        if (sb.sx == sb.sz && sb.sx != 0 && $urandom_range(0, 5) == 0)
          qz = (qz / sb.sz) * sb.sz + qx % sb.sx;
        put_query(qx, qz);
      end
    end
  endtask

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    in_if.valid = 1'b0; in_if.cmd = CMD_WRITE; in_if.cell_col = '0; in_if.cell_row = '0;
    in_if.height_value = '0; in_if.query_x = '0; in_if.query_z = '0;
    cfg_if.valid = 1'b0; cfg_if.reg_index = '0; cfg_if.wdata = '0;
    out_if.ready = 1'b0;
    sb.reset_regs();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed
    put_write(0, 0, HEIGHT_POS_SAT);
    put_write(1, 0, HEIGHT_NEG_SAT);
    put_write(0, 1, 24'h000100);
    put_write(1, 1, HEIGHT_POS_SAT);
    put_query(24'd0, 24'd0);
    put_query(24'd200, 24'd10);
    put_query(24'd10, 24'd200);
    put_query(24'd128, 24'd128);
    put_query(24'd255, 24'd255);
    put_write(255, 255, 24'h123456);
    put_write(254, 254, 24'hFFFFFF);
    put_write(255, 254, 24'h000001);
    put_write(254, 255, 24'h800001);
    put_query(24'd254 * 256 + 255, 24'd254 * 256 + 3);
    put_query(24'd255 * 256, 24'd0);
    put_query(24'd0, 24'd255 * 256);
    put_query(24'hFFFFFF, 24'hFFFFFF);
    random_run(25);

    write_reg(CFG_IDX_UNUSED, 16'hFFFF);
    write_reg(CFG_IDX_SPARE, 16'h0001);
    set_grid(1, 1, 2, 2);
    put_query(24'd0, 24'd0);
    put_query(24'd1, 24'd0);
    random_run(20);

    set_grid(65535, 65535, 256, 256);
    hold_left = HOLD_CYCLES;
    random_run(30);

    set_grid(0, 300, 511, 300);
    random_run(20);
    set_grid(300, 0, 300, 300);
    random_run(20);
    set_grid(256, 256, 1, 0);
    random_run(20);
    set_grid(256, 256, 0, 256);
    random_run(10);

    set_grid(37, 1000, 16, 9);
    random_run(40);
    set_grid(16'hFFFF, 3, 16'hFFFF, 2);
    random_run(20);
    set_grid(100, 100, 40, 40);
    random_run(30);
    calm = 1'b1;
    random_run(30);

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("covered %0d queries (%0d out of grid), %0d height writes, %0d register writes",
             sb.n_query, sb.n_oor, sb.n_write, n_cfg);
    $display("errors: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: heightmap_height_query.f
sv/hhq_pkg.sv
sv/hhq_if.sv
sv/hhq_udiv.sv
sv/heightmap_height_query.sv
dv/tb_top.sv
